>>> design/pfm_pkg.sv
package pfm_pkg;

  // Frame geometry limits.
  localparam int MAX_WIDTH   = 128;
  localparam int MAX_HEIGHT  = 128;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

  // Widths derived from the geometry limits.
  localparam int WD_W   = $clog2(MAX_WIDTH + 1);
  localparam int HT_W   = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
  localparam int SIZE_W = WD_W + HT_W;

  // Fixed field widths.
  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 4 * BYTE_W;
  localparam int PART_W     = 3 * BYTE_W;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH       = 3'd0,
    CFG_IMAGE_HEIGHT      = 3'd1,
    CFG_FOUR_BYTES        = 3'd2,
    CFG_MIRROR_HORIZONTAL = 3'd3,
    CFG_MIRROR_VERTICAL   = 3'd4
  } pfm_cfg_idx_t;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_DRAIN = 1'b1
  } pfm_cmd_code_t;

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } pfm_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;         // load byte accepted
    logic drain_pixel;  // drain accepted with the frame complete
    logic drain_early;  // drain accepted before the frame is complete
  } pfm_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic frame_complete;
  } pfm_status_t;

endpackage

>>> design/pfm_in_if.sv
interface pfm_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

>>> design/pfm_out_if.sv
interface pfm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       last_pixel;
  logic       status;

  modport source (output valid, output red, output green, output blue, output alpha,
                  output last_pixel, output status, input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  input last_pixel, input status, output ready);
endinterface

>>> design/pfm_ctrl.sv
module pfm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_command,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pfm_pkg::pfm_cmd_t    cmd,
  input  pfm_pkg::pfm_status_t status
);
  import pfm_pkg::*;

  pfm_state_t state;
  pfm_state_t state_next;
  logic       accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && (in_command == CMD_DRAIN)) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    out_valid       = 1'b0;
    case (state)
      ST_IDLE: in_ready  = 1'b1;
      ST_RESP: out_valid = 1'b1;
      default: ;
    endcase
    cmd.load        = accept && (in_command == CMD_LOAD);
    cmd.drain_pixel = accept && (in_command == CMD_DRAIN) && status.frame_complete;
    cmd.drain_early = accept && (in_command == CMD_DRAIN) && !status.frame_complete;
  end

endmodule

>>> design/pfm_datapath.sv
module pfm_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pfm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pfm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  pfm_pkg::pfm_cmd_t               cmd,
  output pfm_pkg::pfm_status_t            status,
  input  logic [pfm_pkg::BYTE_W-1:0]      data_byte,
  output logic [pfm_pkg::BYTE_W-1:0]      red,
  output logic [pfm_pkg::BYTE_W-1:0]      green,
  output logic [pfm_pkg::BYTE_W-1:0]      blue,
  output logic [pfm_pkg::BYTE_W-1:0]      alpha,
  output logic                            last_pixel,
  output logic                            pixel_status
);
  import pfm_pkg::*;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] image_width;
  logic [CFG_DATA_W-1:0] image_height;
  logic                  four_bytes;
  logic                  mirror_h;
  logic                  mirror_v;

  // Frame state.
  logic [PART_W-1:0] partial_pixel;
  logic [1:0]        byte_position;
  logic [CNT_W-1:0]  write_count;
  logic [COL_W-1:0]  read_column;
  logic [ROW_W-1:0]  read_row;
  logic              frame_complete;

  // Pixel store.
  logic [WORD_W-1:0] store [STORE_DEPTH];
  logic [WORD_W-1:0] rdata;
  logic              resp_pixel;
  logic              resp_last;
  logic              resp_alpha;

  logic [WD_W-1:0]        w;
  logic [HT_W-1:0]        h;
  logic [WD_W-1:0]        w_m1;
  logic [HT_W-1:0]        h_m1;
  logic [CNT_W-1:0]       size;
  logic                   close_pixel;
  logic                   write_full;
  logic                   store_we;
  logic [WORD_W-1:0]      word;
  logic [PART_W-1:0]      partial_next;
  logic [COL_W-1:0]       col;
  logic [ROW_W-1:0]       row;
  logic [COL_W-1:0]       scol;
  logic [ROW_W-1:0]       srow;
  logic [SIZE_W-1:0]      row_base;
  logic [ADDR_W-1:0]      rd_addr;
  logic                   is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_DATA_W'(MAX_WIDTH);
      image_height <= CFG_DATA_W'(MAX_HEIGHT);
      four_bytes   <= 1'b0;
      mirror_h     <= 1'b0;
      mirror_v     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:       image_width  <= cfg_data;
        CFG_IMAGE_HEIGHT:      image_height <= cfg_data;
        CFG_FOUR_BYTES:        four_bytes   <= cfg_data[0];
        CFG_MIRROR_HORIZONTAL: mirror_h     <= cfg_data[0];
        CFG_MIRROR_VERTICAL:   mirror_v     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective geometry: zero acts as one, large values saturate.
  always_comb begin
    if (image_width == '0) begin
      w = WD_W'(1);
    end else if (16'(image_width) > 16'(MAX_WIDTH)) begin
      w = WD_W'(MAX_WIDTH);
    end else begin
      w = WD_W'(image_width);
    end
    if (image_height == '0) begin
      h = HT_W'(1);
    end else if (16'(image_height) > 16'(MAX_HEIGHT)) begin
      h = HT_W'(MAX_HEIGHT);
    end else begin
      h = HT_W'(image_height);
    end
    w_m1 = w - WD_W'(1);
    h_m1 = h - HT_W'(1);
    size = CNT_W'(SIZE_W'(w) * SIZE_W'(h));
  end

  // Byte gathering.
  always_comb begin
    close_pixel  = four_bytes ? (byte_position == 2'd3) : (byte_position >= 2'd2);
    write_full   = write_count >= size;
    partial_next = partial_pixel;
    case (byte_position)
      2'd0:    partial_next[7:0]   = partial_pixel[7:0]   | data_byte;
      2'd1:    partial_next[15:8]  = partial_pixel[15:8]  | data_byte;
      2'd2:    partial_next[23:16] = partial_pixel[23:16] | data_byte;
      default: partial_next        = partial_pixel;
    endcase
    if (four_bytes) begin
      word = {data_byte, partial_pixel};
    end else begin
      word = {8'h00, partial_pixel[23:16] | data_byte, partial_pixel[15:0]};
    end
    store_we = cmd.load && !frame_complete && !write_full && close_pixel;
  end

  // Drain address.
  always_comb begin
    col      = (WD_W'(read_column) < w) ? read_column : COL_W'(w_m1);
    row      = (HT_W'(read_row) < h) ? read_row : ROW_W'(h_m1);
    scol     = mirror_h ? COL_W'(w_m1 - WD_W'(col)) : col;
    srow     = mirror_v ? ROW_W'(h_m1 - HT_W'(row)) : row;
    row_base = SIZE_W'(srow) * SIZE_W'(w);
    rd_addr  = ADDR_W'(row_base + SIZE_W'(scol));
    is_last  = (WD_W'(col) == w_m1) && (HT_W'(row) == h_m1);
  end

  always_ff @(posedge clk) begin
    if (rst || (cmd.drain_pixel && is_last)) begin
      partial_pixel  <= '0;
      byte_position  <= '0;
      write_count    <= '0;
      read_column    <= '0;
      read_row       <= '0;
      frame_complete <= 1'b0;
    end else if (cmd.load && !frame_complete) begin
      if (write_full) begin
        frame_complete <= 1'b1;
      end else if (close_pixel) begin
        write_count   <= write_count + CNT_W'(1);
        partial_pixel <= '0;
        byte_position <= '0;
        if ((write_count + CNT_W'(1)) >= size) begin
          frame_complete <= 1'b1;
        end
      end else begin
        partial_pixel <= partial_next;
        byte_position <= byte_position + 2'd1;
      end
    end else if (cmd.drain_pixel) begin
      if (WD_W'(col) != w_m1) begin
        read_column <= col + COL_W'(1);
        read_row    <= row;
      end else begin
        read_column <= '0;
        read_row    <= row + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store[ADDR_W'(write_count)] <= word;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.drain_pixel) begin
      rdata <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.drain_pixel || cmd.drain_early) begin
      resp_pixel <= cmd.drain_pixel;
      resp_last  <= is_last;
      resp_alpha <= four_bytes;
    end
  end

  assign status.frame_complete = frame_complete;

  assign red          = resp_pixel ? rdata[23:16] : '0;
  assign green        = resp_pixel ? rdata[15:8]  : '0;
  assign blue         = resp_pixel ? rdata[7:0]   : '0;
  assign alpha        = (resp_pixel && resp_alpha) ? rdata[31:24] : '0;
  assign last_pixel   = resp_pixel && resp_last;
  assign pixel_status = !resp_pixel;

endmodule

>>> design/pixel_frame_mirror.sv
// Channel   Dir  Handshake          Payload
// in_ch     in   valid / ready      command, data_byte
// out_ch    out  valid / ready      red, green, blue, alpha, last_pixel, status
// cfg       in   cfg_we             cfg_index, cfg_data
//
// A load request gives no result; a new request is taken in the cycle after it.
// A drain request reads the store at the accepting edge through its registered
// read port and the result is offered the cycle after, held until out_ch takes
// it. No request is taken while a result waits.
// Reset (rst, synchronous) clears the control state and restores the register
// defaults; the pixel store is not cleared and needs no clearing pass.
module pixel_frame_mirror (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pfm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pfm_pkg::CFG_DATA_W-1:0]  cfg_data,
  pfm_in_if.sink                          in_ch,
  pfm_out_if.source                       out_ch
);
  import pfm_pkg::*;

  // Commands from the controller and the frame status back to it.
  pfm_cmd_t    cmd;
  pfm_status_t dp_status;

  logic [BYTE_W-1:0] red;
  logic [BYTE_W-1:0] green;
  logic [BYTE_W-1:0] blue;
  logic [BYTE_W-1:0] alpha;
  logic              last_pixel;
  logic              pixel_status;

  // The controller owns the handshakes. It decides whether a drain request
  // gets a pixel or a not-ready answer, based on the frame status.
  pfm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .cmd        (cmd),
    .status     (dp_status)
  );

  // The datapath holds the configuration, gathers bytes into pixels, writes
  // the store, walks the mirrored read address and registers the result.
  pfm_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (dp_status),
    .data_byte    (in_ch.data_byte),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha        (alpha),
    .last_pixel   (last_pixel),
    .pixel_status (pixel_status)
  );

  assign out_ch.red        = red;
  assign out_ch.green      = green;
  assign out_ch.blue       = blue;
  assign out_ch.alpha      = alpha;
  assign out_ch.last_pixel = last_pixel;
  assign out_ch.status     = pixel_status;

`ifndef ASSERT_OFF
  // Every drain request produces a result on the next cycle.
  a_drain_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready && (in_ch.command == CMD_DRAIN)) |=> out_ch.valid)
    else $error("drain request did not produce a result");

  // A load request never produces a result.
  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready && (in_ch.command == CMD_LOAD)) |=> !out_ch.valid)
    else $error("load request produced a result");

  // While a result waits, no new request is taken.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready)
    else $error("request taken while a result waits");

  // Handing out the last pixel rearms the frame.
  a_last_rearms: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.last_pixel) |-> !dp_status.frame_complete)
    else $error("frame still complete after its last pixel");
`endif

endmodule
